// ----- hw/rtl/sha1md_pkg.sv -----
`default_nettype none

package sha1md_pkg;

    typedef logic [31:0] word_t;

    // five chaining words, word 0 is H0
    typedef logic [4:0][31:0] chain_t;

    // round constants per twenty-round group
    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    // initial chaining value
    localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

    localparam int ROUNDS    = 80;
    localparam int ROUND_W   = $clog2(ROUNDS);
    localparam int COUNT_W   = 61;
    localparam int NUM_WORDS = 5;
    localparam int OUT_IDX_W = $clog2(NUM_WORDS);

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // commands from the byte sequencer to the round core
    typedef struct packed {
        logic  push;  // shift word into the schedule line
        logic  go;    // this word completes a block, start the rounds
        logic  init;  // reload the initial chaining value
        word_t word;
    } core_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sha1md_core.sv -----
`default_nettype none

module sha1md_core (
    input  wire                   clk,
    input  wire                   rst_n,
    input  sha1md_pkg::core_cmd_t cmd,
    output logic                  done,
    output sha1md_pkg::chain_t    chain
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_FOLD = 3'b100
    } core_state_t;

    core_state_t                     state_reg, state_next;
    logic [sha1md_pkg::ROUND_W-1:0]  round_reg, round_next;
    logic                            done_reg, done_next;
    sha1md_pkg::chain_t              h_reg, h_next;
    sha1md_pkg::chain_t              v_reg, v_next;
    logic [15:0][31:0]               w_reg, w_next;

    sha1md_pkg::word_t a, b, c, d, e;
    sha1md_pkg::word_t f, k, w_new, t;

    // one round of the compression on the working variables
    always_comb
    begin
        a = v_reg[0];
        b = v_reg[1];
        c = v_reg[2];
        d = v_reg[3];
        e = v_reg[4];
        w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_new[30:0], w_new[31]};
        priority if (round_reg < sha1md_pkg::ROUND_W'(20))
        begin
            f = (b & c) | (~b & d);
            k = sha1md_pkg::K_0;
        end
        else if (round_reg < sha1md_pkg::ROUND_W'(40))
        begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K_1;
        end
        else if (round_reg < sha1md_pkg::ROUND_W'(60))
        begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1md_pkg::K_2;
        end
        else
        begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K_3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w_reg[0];
    end

    // sequencer: load, 80 rounds, fold into the chaining words
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        done_next  = 1'b0;
        h_next     = h_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (cmd.init)
                begin
                    h_next = sha1md_pkg::H_INIT;
                end
                if (cmd.push)
                begin
                    w_next = {cmd.word, w_reg[15:1]};
                    if (cmd.go)
                    begin
                        v_next     = h_reg;
                        round_next = '0;
                        state_next = C_RUN;
                    end
                end
            end
            C_RUN:
            begin
                v_next     = {d, c, {b[1:0], b[31:2]}, a, t};
                w_next     = {w_new, w_reg[15:1]};
                round_next = round_reg + 1'b1;
                if (round_reg == sha1md_pkg::ROUND_W'(sha1md_pkg::ROUNDS - 1))
                begin
                    state_next = C_FOLD;
                end
            end
            C_FOLD:
            begin
                for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++)
                begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            done_reg  <= 1'b0;
            h_reg     <= sha1md_pkg::H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            done_reg  <= done_next;
            h_reg     <= h_next;
        end
    end

    // schedule line and working variables
    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end

    assign done  = done_reg;
    assign chain = h_reg;

    // round counter stays inside the 80 rounds
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_RUN) |-> (round_reg < sha1md_pkg::ROUND_W'(sha1md_pkg::ROUNDS)))
        else $error("round counter out of range");

    // done follows the fold cycle only
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> ($past(state_reg) == C_FOLD))
        else $error("done without fold");

    // no word pushed while rounds are running
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (state_reg == C_IDLE))
        else $error("push while core busy");

    // a finished block leaves the core idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == C_IDLE))
        else $error("core not idle after fold");

endmodule

`default_nettype wire

// ----- hw/rtl/sha1_message_digest.sv -----
// SHA-1 digest of a byte stream.
// Input channel s_*: one message byte per item in s_tdata[7:0]; s_tuser says the
// item carries a byte, s_tlast marks the final item of a message. A final item
// with s_tuser low ends the message without a byte (used for the empty message).
// An item with both s_tuser and s_tlast low is taken and ignored.
// Output channel m_*: five 32-bit digest words, H0 first, s_tlast-style m_tlast
// on the fifth word.
// Throughput: one byte per cycle while s_tready is high; the 64th byte of a block
// starts the shared round core (80 rounds, a fold into the chaining words, then
// the sequencer resumes). After the final item the padding bytes go in at one
// per cycle up to the end of the block, each padded block followed by a
// compression (one or two of them), then the five words are offered, one per
// cycle while m_tready is high. The round core is the bottleneck for a long
// message.
// s_tready is low while a block compresses, during padding and while the
// digest is offered; a stalled receiver simply holds the block in that state.
// Reset restores the initial chaining value and clears the byte count; after
// the fifth word is taken the block re-initializes for the next message.

`default_nettype none

module sha1_message_digest (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // data_byte
    input  wire         s_tuser,   // byte_present
    input  wire         s_tlast,   // message_end
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic        m_tlast    // digest_last
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_COMP = 5'b00010,
        S_PAD  = 5'b00100,
        S_PCMP = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t                             state_reg, state_next;
    logic [sha1md_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [23:0]                        acc_reg, acc_next;
    logic [5:0]                         pad_pos_reg, pad_pos_next;
    logic                               pad_first_reg, pad_first_next;
    logic                               len_blk_reg, len_blk_next;
    logic                               fin_reg, fin_next;
    logic                               end_pend_reg, end_pend_next;
    logic [sha1md_pkg::OUT_IDX_W-1:0]   out_idx_reg, out_idx_next;

    sha1md_pkg::core_cmd_t cmd;
    sha1md_pkg::chain_t    chain;
    logic                  core_done;

    logic       in_acc, out_acc;
    logic       push_en;
    logic       init_req;
    logic [7:0] push_byte;
    logic [5:0] push_pos;
    logic       len_eff;
    logic [63:0] bit_len;
    logic [5:0] pos;

    sha1md_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .done  (core_done),
        .chain (chain)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign in_acc   = s_tvalid & s_tready;
    assign out_acc  = m_tvalid & m_tready;
    assign m_tdata  = chain[out_idx_reg];
    assign m_tlast  = (out_idx_reg == sha1md_pkg::OUT_IDX_W'(sha1md_pkg::NUM_WORDS - 1));
    assign bit_len  = {count_reg, 3'b000};
    assign pos      = count_reg[5:0];
    assign len_eff  = pad_first_reg ? (pad_pos_reg[5:3] != 3'b111) : len_blk_reg;

    // byte sequencer: message bytes, padding, length, digest readout
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pad_pos_next   = pad_pos_reg;
        pad_first_next = pad_first_reg;
        len_blk_next   = len_blk_reg;
        fin_next       = fin_reg;
        end_pend_next  = end_pend_reg;
        out_idx_next   = out_idx_reg;
        push_en        = 1'b0;
        push_byte      = s_tdata;
        push_pos       = pos;
        init_req       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser)
                    begin
                        push_en    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tuser && pos == 6'd63)
                    begin
                        end_pend_next = s_tlast;
                        state_next    = S_COMP;
                    end
                    else if (s_tlast)
                    begin
                        pad_pos_next   = s_tuser ? pos + 1'b1 : pos;
                        pad_first_next = 1'b1;
                        state_next     = S_PAD;
                    end
                end
            end
            S_COMP:
            begin
                if (core_done)
                begin
                    if (end_pend_reg)
                    begin
                        pad_pos_next   = '0;
                        pad_first_next = 1'b1;
                        state_next     = S_PAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PAD:
            begin
                push_en  = 1'b1;
                push_pos = pad_pos_reg;
                priority if (pad_first_reg)
                begin
                    push_byte = sha1md_pkg::PAD_BYTE;
                end
                else if (len_eff && pad_pos_reg[5:3] == 3'b111)
                begin
                    push_byte = bit_len[{~pad_pos_reg[2:0], 3'b000} +: 8];
                end
                else
                begin
                    push_byte = 8'h00;
                end
                pad_first_next = 1'b0;
                len_blk_next   = len_eff;
                pad_pos_next   = pad_pos_reg + 1'b1;
                if (pad_pos_reg == 6'd63)
                begin
                    fin_next   = len_eff;
                    state_next = S_PCMP;
                end
            end
            S_PCMP:
            begin
                if (core_done)
                begin
                    if (fin_reg)
                    begin
                        out_idx_next = '0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        len_blk_next = 1'b1;
                        state_next   = S_PAD;
                    end
                end
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    if (m_tlast)
                    begin
                        init_req   = 1'b1;
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // gather bytes into big-endian words for the schedule line
    always_comb
    begin
        cmd.init = init_req;
        cmd.push = push_en && (push_pos[1:0] == 2'b11);
        cmd.go   = cmd.push && (push_pos == 6'd63);
        cmd.word = {acc_reg, push_byte};
        acc_next = push_en ? {acc_reg[15:0], push_byte} : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pad_pos_reg   <= '0;
            pad_first_reg <= 1'b0;
            len_blk_reg   <= 1'b0;
            fin_reg       <= 1'b0;
            end_pend_reg  <= 1'b0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pad_pos_reg   <= pad_pos_next;
            pad_first_reg <= pad_first_next;
            len_blk_reg   <= len_blk_next;
            fin_reg       <= fin_next;
            end_pend_reg  <= end_pend_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // no new item while the digest is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready during digest output");

    // the core only finishes while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> (state_reg == S_COMP || state_reg == S_PCMP))
        else $error("unexpected compression done");

    // the byte count restarts after the final word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (count_reg == '0))
        else $error("byte count not cleared after digest");

    // a block start only comes while taking bytes or padding
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.go |-> (state_reg == S_IDLE || state_reg == S_PAD))
        else $error("block start from wrong state");

endmodule

`default_nettype wire
